[rtl/core/voxel_ray_traversal_macros.svh]
// ----------------------------------------------------------------------------
// voxel_ray_traversal_macros
// assertion macros for the voxel ray traversal checker
// ----------------------------------------------------------------------------
`ifndef VOXEL_RAY_TRAVERSAL_MACROS_SVH
`define VOXEL_RAY_TRAVERSAL_MACROS_SVH

// same-cycle implication
`define VRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/vrt_pkg.sv]
// ----------------------------------------------------------------------------
// vrt_pkg
// shared types, constants and helpers of the voxel ray traversal block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vrt_pkg;

  localparam int T_WIDTH    = 32;
  localparam int CELL_WIDTH = 16;
  localparam int CW         = (CELL_WIDTH > 16) ? CELL_WIDTH : 16;
  localparam int CELL_MAXV  = (1 << (CELL_WIDTH - 1)) - 1;
  localparam int CELL_MINV  = -CELL_MAXV - 1;
  localparam logic [T_WIDTH-1:0] T_MAX = '1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_ADV   = 1'b1;

  typedef struct packed {
    logic signed [CW-1:0] cell_pos;
    logic                 in_range;
    logic signed [1:0]    step;
    logic                 zero;
    logic [T_WIDTH-1:0]   t_next;
    logic [T_WIDTH-1:0]   t_delta;
  } lane_res_t;

  typedef struct packed {
    logic               busy;
    logic               zero;
    logic [T_WIDTH-1:0] t_limit;
  } lim_res_t;

  function automatic logic [T_WIDTH-1:0] tsat(input logic [59:0] v);
    logic [T_WIDTH-1:0] r;
    if (v > 60'(T_MAX)) r = T_MAX;
    else r = v[T_WIDTH-1:0];
    return r;
  endfunction

endpackage

[rtl/core/vrt_if.sv]
// ----------------------------------------------------------------------------
// vrt_if
// input and result channel interfaces
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vrt_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic [31:0]        max_distance;
  modport source (output valid, op, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  max_distance, input ready);
  modport sink (input valid, op, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                max_distance, output ready);
endinterface

interface vrt_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cell_x;
  logic signed [15:0] cell_y;
  logic signed [15:0] cell_z;
  logic signed [1:0]  face_x;
  logic signed [1:0]  face_y;
  logic signed [1:0]  face_z;
  logic               done_res;
  logic               error;
  modport source (output valid, cell_x, cell_y, cell_z, face_x, face_y, face_z, done_res,
                  error, input ready);
  modport sink (input valid, cell_x, cell_y, cell_z, face_x, face_y, face_z, done_res,
                error, output ready);
endinterface

[rtl/core/vrt_lane.sv]
// ----------------------------------------------------------------------------
// vrt_lane
// one axis: origin cell, step sign, squared direction and the two t divides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrt_lane
  import vrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [31:0] origin,
  input  logic signed [15:0] dir,
  output logic [30:0]        sq,
  output logic               busy,
  output lane_res_t          res
);

  logic [15:0]          mag;
  logic [16:0]          n;
  logic [15:0]          mag_r;
  logic [30:0]          num_n_r, num_d_r;
  logic [15:0]          rem_n_r, rem_d_r;
  logic [4:0]           cnt_r;
  logic                 busy_r;
  logic                 zero_r, in_range_r;
  logic signed [1:0]    step_r;
  logic signed [CW-1:0] cell_r;
  logic [30:0]          sq_r;
  logic signed [CW-1:0] cell_c;
  logic [16:0]          tr_n, tr_d;
  logic                 ge_n, ge_d;

  assign mag    = dir[15] ? 16'(-dir) : 16'(dir);
  assign n      = (!dir[15]) ? (17'd65536 - {1'b0, origin[15:0]}) :
                  ((origin[15:0] == 16'd0) ? 17'd65536 : {1'b0, origin[15:0]});
  assign cell_c = CW'($signed(origin[31:16]));

  assign tr_n = {rem_n_r, num_n_r[30]};
  assign tr_d = {rem_d_r, num_d_r[30]};
  assign ge_n = tr_n >= {1'b0, mag_r};
  assign ge_d = tr_d >= {1'b0, mag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r     <= (dir != 16'sd0);
      cnt_r      <= 5'd30;
      mag_r      <= mag;
      sq_r       <= 31'(mag * mag);
      num_n_r    <= {n, 14'd0};
      num_d_r    <= 31'd1 << 30;
      rem_n_r    <= '0;
      rem_d_r    <= '0;
      zero_r     <= (dir == 16'sd0);
      step_r     <= (dir == 16'sd0) ? 2'sd0 : (dir[15] ? -2'sd1 : 2'sd1);
      cell_r     <= cell_c;
      in_range_r <= ($signed(cell_c) >= CELL_MINV) && ($signed(cell_c) <= CELL_MAXV);
    end else if (busy_r) begin
      rem_n_r <= ge_n ? 16'(tr_n - {1'b0, mag_r}) : tr_n[15:0];
      rem_d_r <= ge_d ? 16'(tr_d - {1'b0, mag_r}) : tr_d[15:0];
      num_n_r <= {num_n_r[29:0], ge_n};
      num_d_r <= {num_d_r[29:0], ge_d};
      cnt_r   <= cnt_r - 5'd1;
      if (cnt_r == 5'd0) busy_r <= 1'b0;
    end
  end

  assign sq           = sq_r;
  assign busy         = busy_r;
  assign res.cell_pos = cell_r;
  assign res.in_range = in_range_r;
  assign res.step     = step_r;
  assign res.zero     = zero_r;
  assign res.t_next   = zero_r ? T_MAX : tsat({29'd0, num_n_r});
  assign res.t_delta  = zero_r ? T_MAX : tsat({29'd0, num_d_r});

endmodule

[rtl/core/vrt_limit.sv]
// ----------------------------------------------------------------------------
// vrt_limit
// merges the lane squares: direction length root and limit divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrt_limit
  import vrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] max_dist,
  input  logic [30:0] sq [3],
  output lim_res_t    res
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_SUM  = 4'b0010,
    L_ROOT = 4'b0100,
    L_DIV  = 4'b1000
  } lstate_t;

  lstate_t            state_r, state_nxt;
  logic [31:0]        dist_r;
  logic [60:0]        v_r, r_r, bit_r;
  logic [59:0]        q_r;
  logic [30:0]        rem_r;
  logic [5:0]         cnt_r;
  logic               zero_r;
  logic [T_WIDTH-1:0] lim_r;
  logic [31:0]        sum;
  logic [60:0]        rb;
  logic [31:0]        tr;
  logic               ge;

  assign sum = 32'(sq[0]) + 32'(sq[1]) + 32'(sq[2]);
  assign rb  = r_r + bit_r;
  assign tr  = {rem_r, q_r[59]};
  assign ge  = tr >= {1'b0, r_r[30:0]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE: if (go) state_nxt = L_SUM;
      L_SUM:  state_nxt = (sum == 32'd0) ? L_IDLE : L_ROOT;
      L_ROOT: if (bit_r[0]) state_nxt = L_DIV;
      L_DIV:  if (cnt_r == 6'd0) state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    case (state_r)
      L_IDLE: if (go) dist_r <= max_dist;
      L_SUM: begin
        zero_r <= (sum == 32'd0);
        lim_r  <= '0;
        v_r    <= {1'b0, sum, 28'd0};
        r_r    <= '0;
        bit_r  <= 61'd1 << 60;
      end
      L_ROOT: begin
        if (v_r >= rb) begin
          v_r <= v_r - rb;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        q_r   <= {dist_r, 28'd0};
        rem_r <= '0;
        cnt_r <= 6'd59;
      end
      L_DIV: begin
        rem_r <= ge ? 31'(tr - {1'b0, r_r[30:0]}) : tr[30:0];
        q_r   <= {q_r[58:0], ge};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) lim_r <= tsat({q_r[58:0], ge});
      end
      default: ;
    endcase
  end

  assign res.busy    = (state_r != L_IDLE);
  assign res.zero    = zero_r;
  assign res.t_limit = lim_r;

endmodule

[rtl/core/voxel_ray_traversal.sv]
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// fixed-point 3d grid walk: ray setup across three axis lanes, cell stepping
// ----------------------------------------------------------------------------
// Advances are registered: the next cell and entry face appear the cycle after
// the transfer, so advances can follow each other every cycle while the result
// is taken. A start result is set by the limit unit, which sums the lane
// squares, takes the bit-pair square root, runs the restoring limit divide and
// then loads the result; the per-axis t divides in the lanes run underneath.
// No item is taken while a start is in progress.
`timescale 1ns / 1ps

module voxel_ray_traversal
  import vrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  vrt_in_if.sink    in_chan,
  vrt_out_if.source out_chan
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic signed [CW-1:0] cell_r [3];
  logic signed [1:0]    step_r [3];
  logic [T_WIDTH-1:0]   tn_r [3];
  logic [T_WIDTH-1:0]   td_r [3];
  logic [T_WIDTH-1:0]   tlim_r;
  logic                 active_r;

  logic                 out_valid_r;
  logic signed [15:0]   ocell_r [3];
  logic signed [1:0]    oface_r [3];
  logic                 odone_r, oerr_r;

  logic                 acc, go, adv, fin;
  logic signed [31:0]   org [3];
  logic signed [15:0]   dir [3];
  logic [30:0]          sq [3];
  logic [2:0]           lbusy;
  lane_res_t            lres [3];
  lim_res_t             lim;

  logic [1:0]           a;
  logic [T_WIDTH-1:0]   sel_t, sel_d;
  logic signed [CW-1:0] sel_c;
  logic signed [1:0]    sel_s;
  logic signed [CW:0]   nc;
  logic [T_WIDTH:0]     tsum;
  logic                 stop;
  logic                 step_ok;
  logic                 all_in;

  assign org[0] = in_chan.origin_x;
  assign org[1] = in_chan.origin_y;
  assign org[2] = in_chan.origin_z;
  assign dir[0] = in_chan.dir_x;
  assign dir[1] = in_chan.dir_y;
  assign dir[2] = in_chan.dir_z;

  assign in_chan.ready = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign acc = in_chan.valid && in_chan.ready;
  assign go  = acc && (in_chan.op == OP_START);
  assign adv = acc && (in_chan.op == OP_ADV);
  assign fin = (state_r == S_RUN) && (lbusy == 3'b000) && !lim.busy;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    vrt_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .go     (go),
      .origin (org[k]),
      .dir    (dir[k]),
      .sq     (sq[k]),
      .busy   (lbusy[k]),
      .res    (lres[k])
    );
  end

  vrt_limit u_limit (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .max_dist (in_chan.max_distance),
    .sq       (sq),
    .res      (lim)
  );

  assign all_in = lres[0].in_range && lres[1].in_range && lres[2].in_range;

  // axis pick: smallest t_next, a tie goes to the higher axis
  always_comb begin
    if (tn_r[0] < tn_r[1]) a = (tn_r[0] < tn_r[2]) ? 2'd0 : 2'd2;
    else a = (tn_r[1] < tn_r[2]) ? 2'd1 : 2'd2;
    case (a)
      2'd0: begin
        sel_t = tn_r[0]; sel_d = td_r[0]; sel_c = cell_r[0]; sel_s = step_r[0];
      end
      2'd1: begin
        sel_t = tn_r[1]; sel_d = td_r[1]; sel_c = cell_r[1]; sel_s = step_r[1];
      end
      default: begin
        sel_t = tn_r[2]; sel_d = td_r[2]; sel_c = cell_r[2]; sel_s = step_r[2];
      end
    endcase
  end

  assign nc   = $signed({sel_c[CW-1], sel_c}) + (CW+1)'(sel_s);
  assign tsum = {1'b0, sel_t} + {1'b0, sel_d};
  assign stop = (sel_t > tlim_r) || (sel_t == T_MAX) || (nc < CELL_MINV) || (nc > CELL_MAXV);
  assign step_ok = active_r && !stop;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (go) state_nxt = S_RUN;
      S_RUN:  if (fin) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      tlim_r      <= '0;
      for (int k = 0; k < 3; k++) begin
        cell_r[k] <= '0;
        step_r[k] <= '0;
        tn_r[k]   <= T_MAX;
        td_r[k]   <= T_MAX;
      end
    end else begin
      state_r <= state_nxt;
      if (fin) begin
        for (int k = 0; k < 3; k++) begin
          cell_r[k]  <= lres[k].cell_pos;
          step_r[k]  <= lres[k].step;
          tn_r[k]    <= lres[k].t_next;
          td_r[k]    <= lres[k].t_delta;
          ocell_r[k] <= lres[k].cell_pos[15:0];
          oface_r[k] <= 2'sd0;
        end
        tlim_r      <= lim.zero ? '0 : lim.t_limit;
        active_r    <= !lim.zero && all_in;
        odone_r     <= lim.zero || !all_in;
        oerr_r      <= lim.zero;
        out_valid_r <= 1'b1;
      end else if (adv) begin
        out_valid_r <= 1'b1;
        odone_r     <= !active_r || stop;
        oerr_r      <= !active_r;
        if (active_r && stop) active_r <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          if (step_ok && (a == 2'(k))) begin
            cell_r[k]  <= nc[CW-1:0];
            tn_r[k]    <= tsum[T_WIDTH] ? T_MAX : tsum[T_WIDTH-1:0];
            ocell_r[k] <= nc[15:0];
            oface_r[k] <= -sel_s;
          end else begin
            ocell_r[k] <= cell_r[k][15:0];
            oface_r[k] <= 2'sd0;
          end
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.cell_x   = ocell_r[0];
  assign out_chan.cell_y   = ocell_r[1];
  assign out_chan.cell_z   = ocell_r[2];
  assign out_chan.face_x   = oface_r[0];
  assign out_chan.face_y   = oface_r[1];
  assign out_chan.face_z   = oface_r[2];
  assign out_chan.done_res = odone_r;
  assign out_chan.error    = oerr_r;

endmodule

[rtl/core/vrt_checker.sv]
// ----------------------------------------------------------------------------
// vrt_checker
// port-level checks of the voxel ray traversal result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voxel_ray_traversal_macros.svh"

module vrt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] cell_x,
  input logic signed [1:0] face_x,
  input logic signed [1:0] face_y,
  input logic signed [1:0] face_z,
  input logic              done_res,
  input logic              error
);

  `VRT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `VRT_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(cell_x), "stalled result changed")
  `VRT_ASSERT_IMP(a_err_done, out_valid && error, done_res, "error without done")
  `VRT_ASSERT_IMP(a_face_one, out_valid && (face_x != 2'sd0),
                  !done_res && (face_y == 2'sd0) && (face_z == 2'sd0), "bad entry face")

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .cell_x    (out_chan.cell_x),
  .face_x    (out_chan.face_x),
  .face_y    (out_chan.face_y),
  .face_z    (out_chan.face_z),
  .done_res  (out_chan.done_res),
  .error     (out_chan.error)
);
